FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CHK_IMPLY(lbl, clk, rst, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) else $error(msg);

// next-cycle implication, quiet during reset
`define CHK_NEXT(lbl, clk, rst, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) else $error(msg);

// next-cycle implication, also checked across reset
`define CHK_NEXT_ALWAYS(lbl, clk, pre, con, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (con)) else $error(msg);

`endif

FILE: rtl/hmmd_pkg.sv
// ---------------------------------------------------------------------------
// hmmd_pkg
// Shared types and constants of the hazard mask margin dilation block.
// ---------------------------------------------------------------------------
package hmmd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HALO_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS    = 3'd4;

  // cell flag bit positions
  localparam int FLAG_LAND      = 0;
  localparam int FLAG_DRYING    = 1;
  localparam int FLAG_SHALLOW   = 2;
  localparam int FLAG_UNK_DEPTH = 3;
  localparam int FLAG_NO_CHART  = 4;
  localparam int FLAG_UNK_CLASS = 5;
  localparam int FLAG_MARGIN    = 6;
  localparam int FLAG_NEED_TILE = 7;

  localparam int BASE_FLAGS_W = 6;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_PTR_W      = 2;
  localparam int OUT_LVL_W      = 3;

  // one history entry: bits kept per grid cell
  typedef struct packed {
    logic                    ms;
    logic                    hz;
    logic [BASE_FLAGS_W-1:0] base;
  } hist_t;

  typedef struct packed {
    logic [7:0] flags;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } result_t;

endpackage

FILE: rtl/hazard_mask_margin_dilation.sv
// ---------------------------------------------------------------------------
// hazard_mask_margin_dilation
// Hazard mask with square-window margin dilation over a halo-extended grid.
// ---------------------------------------------------------------------------
// Usage:
//   Cells of the (rows + 2h) x (cols + 2h) grid enter in raster order on the
//   input channel (in_valid / in_stall). Interior cells leave on the output
//   channel (out_valid / out_stall) with their flags and interior position;
//   halo cells give no word.
//   One cell is taken per cycle while in_stall is low. The cell at the
//   bottom-right corner of a window completes it: its accepting edge
//   registers the history and column-count RAM reads into stage 1, stage 2
//   registers the count update and window sums, and the flag compare is
//   then pushed into the output buffer. The column-count RAM is read and
//   written back for every accepted cell; a one-entry write register
//   forwards the last update. A 4-word output buffer absorbs receiver
//   stalls; in_stall rises once the buffer plus the two words in flight
//   would fill it. Reset loads the register defaults and restarts the tile.
//   The history RAM needs no clearing pass: every entry is written before
//   it is read. Writing the halo radius or a tile size restarts the tile;
//   configure only while idle.
// ---------------------------------------------------------------------------
module hazard_mask_margin_dilation #(
  parameter int MAX_HALO       = 128,
  parameter int MAX_TILE_CELLS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hmmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hmmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              land_hazard,
  input  logic                              drying_hazard,
  input  logic                              no_chart,
  input  logic                              unknown_class,
  input  logic                              depth_known,
  input  logic signed [15:0]                cell_depth_cm,
  input  logic                              cell_missing,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        cell_flags,
  output logic [5:0]                        out_row,
  output logic [5:0]                        out_col,
  output logic                              last_cell
);
  import hmmd_pkg::*;

  localparam int RING  = 2 * MAX_HALO + 1;
  localparam int GC    = 2 * MAX_HALO + MAX_TILE_CELLS;
  localparam int HDEP  = RING * GC;
  localparam int HW    = $clog2(MAX_HALO + 1);
  localparam int TSW   = $clog2(MAX_TILE_CELLS + 1);
  localparam int PW    = $clog2(GC);
  localparam int EW    = $clog2(GC + 1);
  localparam int SW    = $clog2(RING);
  localparam int AW    = $clog2(HDEP);
  localparam int CW    = $clog2(RING + 1);
  localparam int SUMW  = $clog2(RING * RING + 1);

  typedef struct packed {
    logic [CW-1:0] hz;
    logic [CW-1:0] ms;
  } cnt_t;

  typedef struct packed {
    logic          emit;
    logic          zero_old;
    logic          sub_en;
    logic          first_col;
    logic          sub_col;
    logic          cen_self;
    logic [PW-1:0] col_c;
    hist_t         own;
    logic [5:0]    row;
    logic [5:0]    col;
    logic          last;
  } s1_t;

  typedef struct packed {
    logic       emit;
    hist_t      cen;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } s2_t;

  // configuration
  logic [7:0]         halo_radius;
  logic               check_depth_enable;
  logic signed [15:0] min_depth_cm;
  logic [6:0]         tile_rows;
  logic [6:0]         tile_cols;
  logic               geo_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      halo_radius        <= '0;
      check_depth_enable <= 1'b0;
      min_depth_cm       <= '0;
      tile_rows          <= 7'd40;
      tile_cols          <= 7'd40;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALO_RADIUS: halo_radius        <= cfg_data[7:0];
        REG_CHECK_DEPTH: check_depth_enable <= cfg_data[0];
        REG_MIN_DEPTH:   min_depth_cm       <= cfg_data;
        REG_TILE_ROWS:   tile_rows          <= cfg_data[6:0];
        REG_TILE_COLS:   tile_cols          <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign geo_write = cfg_we && (cfg_index == REG_HALO_RADIUS ||
                                cfg_index == REG_TILE_ROWS ||
                                cfg_index == REG_TILE_COLS);

  // effective geometry
  logic [HW-1:0]  halo_eff;
  logic [TSW-1:0] rows_eff;
  logic [TSW-1:0] cols_eff;
  logic [EW-1:0]  two_h;
  logic [EW-1:0]  win_w;
  logic [EW-1:0]  ext_rows;
  logic [EW-1:0]  ext_cols;

  always_comb begin
    halo_eff = (int'(halo_radius) > MAX_HALO) ? HW'(MAX_HALO) : HW'(halo_radius);
    if (tile_rows == '0) begin
      rows_eff = TSW'(1);
    end else if (int'(tile_rows) > MAX_TILE_CELLS) begin
      rows_eff = TSW'(MAX_TILE_CELLS);
    end else begin
      rows_eff = TSW'(tile_rows);
    end
    if (tile_cols == '0) begin
      cols_eff = TSW'(1);
    end else if (int'(tile_cols) > MAX_TILE_CELLS) begin
      cols_eff = TSW'(MAX_TILE_CELLS);
    end else begin
      cols_eff = TSW'(tile_cols);
    end
    two_h    = EW'({halo_eff, 1'b0});
    win_w    = two_h + EW'(1);
    ext_rows = EW'(rows_eff) + two_h;
    ext_cols = EW'(cols_eff) + two_h;
  end

  // input side
  logic                 acc;
  logic [PW-1:0]        pos_r;
  logic [PW-1:0]        pos_c;
  logic [SW-1:0]        slot;
  logic [AW-1:0]        sbase;
  logic [EW-1:0]        r_e;
  logic [EW-1:0]        c_e;
  logic [AW-1:0]        hoff;
  logic [AW-1:0]        cen_base;
  logic [AW-1:0]        addr_w;
  logic [AW-1:0]        addr_cen;
  logic [PW-1:0]        col_cw;
  logic [BASE_FLAGS_W-1:0] base;
  hist_t                own_word;
  logic                 emit0;
  logic                 last_c;
  logic                 last_r;
  logic                 s1_valid;
  logic                 s2_valid;
  logic [OUT_LVL_W-1:0] fifo_level;

  assign in_stall = (int'(fifo_level) + int'(s1_valid) + int'(s2_valid)) >= OUT_FIFO_DEPTH;
  assign acc      = in_valid && !in_stall;

  assign r_e      = EW'(pos_r);
  assign c_e      = EW'(pos_c);
  assign hoff     = AW'(halo_eff) * AW'(GC);
  // ring row of the window centre, h rows above the current row
  assign cen_base = (EW'(slot) >= EW'(halo_eff)) ? (sbase - hoff)
                                                  : (sbase + hoff + AW'(GC));
  assign addr_w   = sbase + AW'(pos_c);
  assign addr_cen = cen_base + AW'(pos_c) - AW'(halo_eff);
  assign col_cw   = PW'(c_e - win_w);
  assign emit0    = (r_e >= two_h) && (c_e >= two_h);
  assign last_c   = (c_e == ext_cols - EW'(1));
  assign last_r   = (r_e == ext_rows - EW'(1));

  always_comb begin
    base = '0;
    base[FLAG_LAND]      = land_hazard;
    base[FLAG_DRYING]    = drying_hazard;
    base[FLAG_NO_CHART]  = no_chart;
    base[FLAG_UNK_CLASS] = unknown_class;
    if (check_depth_enable) begin
      if (!depth_known) begin
        if (!(land_hazard || drying_hazard || no_chart)) begin
          base[FLAG_UNK_DEPTH] = 1'b1;
        end
      end else if (cell_depth_cm < min_depth_cm) begin
        base[FLAG_SHALLOW] = 1'b1;
      end
    end
    own_word.base = base;
    own_word.hz   = base[FLAG_LAND] | base[FLAG_DRYING] | base[FLAG_SHALLOW];
    own_word.ms   = cell_missing;
  end

  // raster position and ring slot
  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      pos_r <= '0;
      pos_c <= '0;
      slot  <= '0;
      sbase <= '0;
    end else if (acc) begin
      if (!last_c) begin
        pos_c <= pos_c + PW'(1);
      end else begin
        pos_c <= '0;
        if (last_r) begin
          pos_r <= '0;
          slot  <= '0;
          sbase <= '0;
        end else begin
          pos_r <= pos_r + PW'(1);
          if (EW'(slot) == win_w - EW'(1)) begin
            slot  <= '0;
            sbase <= '0;
          end else begin
            slot  <= slot + SW'(1);
            sbase <= sbase + AW'(GC);
          end
        end
      end
    end
  end

  // memories
  hist_t hist_old;
  hist_t hist_cen;
  cnt_t  cnt_c_rd;
  cnt_t  cnt_cw_rd;
  cnt_t  cnt_new;
  s1_t   s1;

  hmmd_ram #(.WIDTH($bits(hist_t)), .DEPTH(HDEP)) u_hist_ram (
    .clk     (clk),
    .we      (acc),
    .waddr   (addr_w),
    .wdata   (own_word),
    .re_a    (acc),
    .raddr_a (addr_w),
    .rdata_a (hist_old),
    .re_b    (acc && emit0),
    .raddr_b (addr_cen),
    .rdata_b (hist_cen)
  );

  hmmd_ram #(.WIDTH($bits(cnt_t)), .DEPTH(GC)) u_count_ram (
    .clk     (clk),
    .we      (s1_valid),
    .waddr   (s1.col_c),
    .wdata   (cnt_new),
    .re_a    (acc),
    .raddr_a (pos_c),
    .rdata_a (cnt_c_rd),
    .re_b    (acc),
    .raddr_b (col_cw),
    .rdata_b (cnt_cw_rd)
  );

  // stage 1 payload
  logic [PW-1:0] s1_col_cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1.emit      <= emit0;
      s1.zero_old  <= (pos_r == '0);
      s1.sub_en    <= (r_e >= win_w);
      s1.first_col <= (pos_c == '0);
      s1.sub_col   <= (c_e >= win_w);
      s1.cen_self  <= (halo_eff == '0);
      s1.col_c     <= pos_c;
      s1.own       <= own_word;
      s1.row       <= 6'(r_e - two_h);
      s1.col       <= 6'(c_e - two_h);
      s1.last      <= last_c && last_r;
      s1_col_cw    <= col_cw;
    end
  end

  // stage 1: column count update and window sums
  logic          wq_valid;
  logic [PW-1:0] wq_addr;
  cnt_t          wq_data;
  cnt_t          cnt_c;
  cnt_t          cnt_cw;
  cnt_t          cnt_old;
  cnt_t          cnt_sub;
  logic [SUMW-1:0] hsum;
  logic [SUMW-1:0] msum;
  logic [SUMW-1:0] hsum_next;
  logic [SUMW-1:0] msum_next;

  always_comb begin
    // last write landed on the edge that issued this read
    cnt_c   = (wq_valid && wq_addr == s1.col_c) ? wq_data : cnt_c_rd;
    cnt_cw  = (wq_valid && wq_addr == s1_col_cw) ? wq_data : cnt_cw_rd;
    cnt_old = s1.zero_old ? '0 : cnt_c;
    cnt_new.hz = cnt_old.hz - CW'(s1.sub_en & hist_old.hz) + CW'(s1.own.hz);
    cnt_new.ms = cnt_old.ms - CW'(s1.sub_en & hist_old.ms) + CW'(s1.own.ms);
    cnt_sub = s1.sub_col ? cnt_cw : '0;
    hsum_next = (s1.first_col ? '0 : hsum) + SUMW'(cnt_new.hz) - SUMW'(cnt_sub.hz);
    msum_next = (s1.first_col ? '0 : msum) + SUMW'(cnt_new.ms) - SUMW'(cnt_sub.ms);
  end

  s2_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wq_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        wq_valid <= 1'b1;
      end
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      wq_addr <= s1.col_c;
      wq_data <= cnt_new;
      hsum    <= hsum_next;
      msum    <= msum_next;
      s2.emit <= s1.emit;
      s2.cen  <= s1.cen_self ? s1.own : hist_cen;
      s2.row  <= s1.row;
      s2.col  <= s1.col;
      s2.last <= s1.last;
    end
  end

  // stage 2: window flags, the centre itself excluded
  logic    need_tile;
  logic    margin;
  result_t res;
  result_t head;

  always_comb begin
    need_tile = msum > SUMW'(s2.cen.ms);
    margin    = !need_tile && (hsum > SUMW'(s2.cen.hz));
    res.flags = {2'b00, s2.cen.base};
    res.flags[FLAG_NEED_TILE] = need_tile;
    res.flags[FLAG_MARGIN]    = margin;
    res.row   = s2.row;
    res.col   = s2.col;
    res.last  = s2.last;
  end

  hmmd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid && s2.emit),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head),
    .level     (fifo_level)
  );

  assign cell_flags = head.flags;
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign last_cell  = head.last;

endmodule

FILE: rtl/hmmd_ram.sv
// ---------------------------------------------------------------------------
// hmmd_ram
// Synchronous RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module hmmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // reads return the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/hmmd_out_fifo.sv
// ---------------------------------------------------------------------------
// hmmd_out_fifo
// Small result buffer between the window pipeline and the output channel.
// ---------------------------------------------------------------------------
module hmmd_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  hmmd_pkg::result_t          push_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hmmd_pkg::result_t          head,
  output logic [hmmd_pkg::OUT_LVL_W-1:0] level
);
  import hmmd_pkg::*;

  result_t               entries [OUT_FIFO_DEPTH];
  logic [OUT_PTR_W-1:0]  wptr;
  logic [OUT_PTR_W-1:0]  rptr;
  logic                  pop;

  assign out_valid = (level != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + OUT_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + OUT_LVL_W'(1);
        2'b01:   level <= level - OUT_LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

FILE: rtl/hmmd_checker.sv
// ---------------------------------------------------------------------------
// hmmd_checker
// Port-level checks of the hazard mask margin dilation block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hmmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cell_flags,
  input logic       last_cell
);
  import hmmd_pkg::*;

  // a held word keeps its content
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cell_flags) && $stable(last_cell), "output word changed while stalled")

  // needs-tile takes priority over margin
  `CHK_IMPLY(a_flag_prio, clk, rst, out_valid, !(cell_flags[FLAG_NEED_TILE] && cell_flags[FLAG_MARGIN]), "margin and needs-tile both set")

  // depth flags come from exclusive branches
  `CHK_IMPLY(a_depth_excl, clk, rst, out_valid, !(cell_flags[FLAG_SHALLOW] && cell_flags[FLAG_UNK_DEPTH]), "shallow and unknown depth both set")

  // reset empties the output buffer
  `CHK_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "word shown right after reset")

endmodule

bind hazard_mask_margin_dilation hmmd_checker u_hmmd_checker (.*);
